### sv/enr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enr_pkg
// Shared types and codes for the epsilon-move removal block: input function
// codes, register indexes, classified command format and engine states.
// ----------------------------------------------------------------------------
package enr_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_NUM_STATES  = 1'b0;
  localparam logic REG_NUM_SYMBOLS = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned CFG_W  = 5;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified command kinds
  typedef enum logic [1:0] {
    K_CLEAR,
    K_ADD_EPS,
    K_ADD_SYM,
    K_QUERY
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] sym;
    logic [IDX_W-1:0] dst;
  } cmd_t;

  // Back-end engine states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CL_ISSUE,
    ST_CL_ABSORB,
    ST_SYM_SCAN,
    ST_EMIT
  } st_e;

endpackage
`default_nettype wire

### sv/enr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enr_front
// Input side: accepts transactions, checks indexes against the configured
// sizes and turns each useful item into a command for the queue.
// ----------------------------------------------------------------------------
module enr_front
  import enr_pkg::*;
#(
  parameter int unsigned CW  = 5,
  parameter int unsigned YCW = 5
) (
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [IDX_W-1:0]     src_state_i,
  input  wire logic [IDX_W-1:0]     symbol_i,
  input  wire logic [IDX_W-1:0]     dst_state_i,
  input  wire logic                 is_epsilon_i,
  input  wire logic [CW-1:0]        ns_i,
  input  wire logic [YCW-1:0]       nsym_i,
  input  wire logic                 q_full_i,
  input  wire logic                 busy_clear_i,
  output      logic                 push_o,
  output      cmd_t                 push_cmd_o
);

  logic accept;
  logic src_ok;
  logic dst_ok;
  logic sym_ok;
  logic keep;

  // Hold off while the queue is full or the tables are being swept
  assign in_stall_o = q_full_i | busy_clear_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Range checks against the saturated sizes
  assign src_ok = 8'(src_state_i) < 8'(ns_i);
  assign dst_ok = 8'(dst_state_i) < 8'(ns_i);
  assign sym_ok = 8'(symbol_i) < 8'(nsym_i);

  // Classify and drop items that have no effect
  always_comb begin
    keep            = 1'b0;
    push_cmd_o.kind = K_CLEAR;
    push_cmd_o.src  = src_state_i;
    push_cmd_o.sym  = symbol_i;
    push_cmd_o.dst  = dst_state_i;
    case (func_i)
      FUNC_CLEAR: begin
        keep = 1'b1;
      end
      FUNC_ADD: begin
        if (is_epsilon_i) begin
          push_cmd_o.kind = K_ADD_EPS;
          keep            = src_ok & dst_ok;
        end else begin
          push_cmd_o.kind = K_ADD_SYM;
          keep            = src_ok & dst_ok & sym_ok;
        end
      end
      FUNC_QUERY: begin
        push_cmd_o.kind = K_QUERY;
        keep            = src_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept & keep;

endmodule
`default_nettype wire

### sv/enr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enr_queue
// Short command FIFO that decouples the input side from the table engine.
// ----------------------------------------------------------------------------
module enr_queue
  import enr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      cmd_t head_o,
  output      logic empty_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = cnt_q == NW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### sv/enr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enr_back
// Table engine: holds the epsilon and symbol transition memories, sweeps
// them clear, applies adds, and answers queries with a closure walk and one
// accumulation scan per symbol into an output register.
// ----------------------------------------------------------------------------
module enr_back
  import enr_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned CW          = 5,
  parameter int unsigned YCW         = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CW-1:0]       ns_i,
  input  wire logic [YCW-1:0]      nsym_i,
  input  wire logic                q_empty_i,
  input  wire cmd_t                q_head_i,
  output      logic                q_pop_o,
  output      logic                busy_clear_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [IDX_W-1:0]    from_state_o,
  output      logic [IDX_W-1:0]    out_symbol_o,
  output      logic [MASK_W-1:0]   target_mask_o,
  output      logic [MASK_W-1:0]   closure_mask_o,
  output      logic                last_o
);

  localparam int unsigned MW = MAX_STATES;
  localparam int unsigned SW = $clog2(MAX_STATES);
  localparam int unsigned YW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned AW = SW + YW;
  localparam int unsigned ES = 2 ** SW;
  localparam int unsigned TS = 2 ** AW;

  // Index of the single set bit of a one-hot word
  function automatic logic [SW-1:0] oh_index(input logic [MW-1:0] oh);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MW; i++) begin
      if (oh[i]) begin
        idx = idx | SW'(i);
      end
    end
    return idx;
  endfunction

  // Memories
  logic [MW-1:0] eps_mem [ES];
  logic [MW-1:0] tgt_mem [TS];
  logic [MW-1:0] eps_rd_q;
  logic [MW-1:0] tgt_rd_q;

  logic          eps_we;
  logic [SW-1:0] eps_wa;
  logic [MW-1:0] eps_wd;
  logic [SW-1:0] eps_ra;
  logic          tgt_we;
  logic [AW-1:0] tgt_wa;
  logic [MW-1:0] tgt_wd;
  logic [AW-1:0] tgt_ra;

  // Control and datapath registers
  st_e           state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic [MW-1:0] closure_q, closure_d;
  logic [MW-1:0] visited_q, visited_d;
  logic [MW-1:0] scan_q, scan_d;
  logic [MW-1:0] acc_q, acc_d;
  logic [YW-1:0] sym_q, sym_d;
  logic          rd_pend_q, rd_pend_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  from_q;
  logic [IDX_W-1:0]  osym_q;
  logic [MASK_W-1:0] tmask_q;
  logic [MASK_W-1:0] cmask_q;
  logic              last_q;
  logic              out_load;

  // Shared terms
  logic [MW:0]   live_w;
  logic [MW-1:0] live;
  logic [MW-1:0] pending;
  logic [MW-1:0] pend_low;
  logic [MW-1:0] scan_low;
  logic [MW-1:0] acc_next;
  logic [MW-1:0] dst_bit;
  logic          clr_done;
  logic          out_free;
  logic          sym_last;

  assign live_w   = ((MW + 1)'(1) << ns_i) - (MW + 1)'(1);
  assign live     = live_w[MW-1:0];
  assign pending  = closure_q & ~visited_q;
  assign pend_low = pending & (~pending + MW'(1));
  assign scan_low = scan_q & (~scan_q + MW'(1));
  assign acc_next = rd_pend_q ? (acc_q | tgt_rd_q) : acc_q;
  assign dst_bit  = MW'(1) << cmd_q.dst;
  assign clr_done = clr_idx_q == {AW{1'b1}};
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign sym_last = (8'(sym_q) + 8'd1) == 8'(nsym_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_head_i.kind)
            K_CLEAR:   state_d = ST_CLEAR;
            K_QUERY:   state_d = ST_CL_ISSUE;
            default:   state_d = ST_ADD_RD;
          endcase
        end
      end
      ST_ADD_RD:    state_d = ST_ADD_WR;
      ST_ADD_WR:    state_d = ST_IDLE;
      ST_CL_ISSUE: begin
        state_d = (pending == '0) ? ST_SYM_SCAN : ST_CL_ABSORB;
      end
      ST_CL_ABSORB: state_d = ST_CL_ISSUE;
      ST_SYM_SCAN: begin
        if (scan_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = sym_last ? ST_IDLE : ST_SYM_SCAN;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    q_pop_o   = 1'b0;
    eps_we    = 1'b0;
    eps_wa    = SW'(cmd_q.src);
    eps_wd    = '0;
    eps_ra    = SW'(cmd_q.src);
    tgt_we    = 1'b0;
    tgt_wa    = {SW'(cmd_q.src), YW'(cmd_q.sym)};
    tgt_wd    = '0;
    tgt_ra    = {SW'(cmd_q.src), YW'(cmd_q.sym)};
    cmd_d     = cmd_q;
    clr_idx_d = clr_idx_q;
    closure_d = closure_q;
    visited_d = visited_q;
    scan_d    = scan_q;
    acc_d     = acc_q;
    sym_d     = sym_q;
    rd_pend_d = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // Sweep both tables to zero
        eps_we    = 1'b1;
        eps_wa    = clr_idx_q[AW-1:YW];
        tgt_we    = 1'b1;
        tgt_wa    = clr_idx_q;
        clr_idx_d = clr_idx_q + AW'(1);
      end
      ST_IDLE: begin
        // Take the next command
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          cmd_d     = q_head_i;
          clr_idx_d = '0;
          closure_d = MW'(1) << q_head_i.src;
          visited_d = '0;
        end
      end
      ST_ADD_RD: begin
        eps_ra = SW'(cmd_q.src);
        tgt_ra = {SW'(cmd_q.src), YW'(cmd_q.sym)};
      end
      ST_ADD_WR: begin
        // Merge the new destination into the stored row
        if (cmd_q.kind == K_ADD_EPS) begin
          eps_we = 1'b1;
          eps_wd = eps_rd_q | dst_bit;
        end else begin
          tgt_we = 1'b1;
          tgt_wd = tgt_rd_q | dst_bit;
        end
      end
      ST_CL_ISSUE: begin
        // Read epsilon row of the lowest unvisited closure state
        eps_ra    = oh_index(pend_low);
        visited_d = visited_q | pend_low;
        if (pending == '0) begin
          sym_d  = '0;
          scan_d = closure_q;
          acc_d  = '0;
        end
      end
      ST_CL_ABSORB: begin
        closure_d = closure_q | (eps_rd_q & live);
      end
      ST_SYM_SCAN: begin
        // Read one closure state's row per cycle, accumulate each row once its registered read returns
        tgt_ra = {oh_index(scan_low), sym_q};
        acc_d  = acc_next;
        if (scan_q != '0) begin
          scan_d    = scan_q & ~scan_low;
          rd_pend_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          sym_d    = sym_q + YW'(1);
          scan_d   = closure_q;
          acc_d    = '0;
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    closure_q <= closure_d;
    visited_q <= visited_d;
    scan_q    <= scan_d;
    acc_q     <= acc_d;
    sym_q     <= sym_d;
  end

  // Table memories with registered reads
  always_ff @(posedge clk_i) begin
    if (eps_we) begin
      eps_mem[eps_wa] <= eps_wd;
    end
    eps_rd_q <= eps_mem[eps_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    tgt_rd_q <= tgt_mem[tgt_ra];
  end

  // Hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      from_q  <= cmd_q.src;
      osym_q  <= IDX_W'(sym_q);
      tmask_q <= MASK_W'(acc_q & live);
      cmask_q <= MASK_W'(closure_q);
      last_q  <= sym_last;
    end
  end

  assign busy_clear_o   = state_q == ST_CLEAR;
  assign out_valid_o    = out_valid_q;
  assign from_state_o   = from_q;
  assign out_symbol_o   = osym_q;
  assign target_mask_o  = tmask_q;
  assign closure_mask_o = cmask_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

### sv/epsilon_nfa_removal.sv
`default_nettype none
// An add reads the stored row and writes it back merged with the new
// destination; a query walks the epsilon closure, then scans the rows of
// the closure states for each symbol in turn and emits one result per
// symbol. The engine works on one item at a time.
// Reset and clear sweep both tables, one entry a cycle; no item is taken
// during the sweep.
// ----------------------------------------------------------------------------
// epsilon_nfa_removal
// Automaton table with epsilon-closure queries: configuration registers,
// input classification, command queue and table engine.
// ----------------------------------------------------------------------------
module epsilon_nfa_removal
  import enr_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready,
  // Input channel
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [IDX_W-1:0]    src_state_i,
  input  wire logic [IDX_W-1:0]    symbol_i,
  input  wire logic [IDX_W-1:0]    dst_state_i,
  input  wire logic                is_epsilon_i,
  // Output channel
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [IDX_W-1:0]    from_state_o,
  output      logic [IDX_W-1:0]    out_symbol_o,
  output      logic [MASK_W-1:0]   target_mask_o,
  output      logic [MASK_W-1:0]   closure_mask_o,
  output      logic                last_o
);

  localparam int unsigned CW  = $clog2(MAX_STATES + 1);
  localparam int unsigned YCW = $clog2(MAX_SYMBOLS + 1);

  logic [CFG_W-1:0] num_states_q, num_states_d;
  logic [CFG_W-1:0] num_symbols_q, num_symbols_d;
  logic             cfg_wr;
  logic [CW-1:0]    ns;
  logic [YCW-1:0]   nsym;

  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  cmd_t             q_head;
  logic             busy_clear;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    num_states_d  = num_states_q;
    num_symbols_d = num_symbols_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_STATES:  num_states_d  = pwdata[CFG_W-1:0];
        REG_NUM_SYMBOLS: num_symbols_d = pwdata[CFG_W-1:0];
        default:         num_states_d  = num_states_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= CFG_W'(16);
      num_symbols_q <= CFG_W'(16);
    end else begin
      num_states_q  <= num_states_d;
      num_symbols_q <= num_symbols_d;
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      REG_NUM_STATES:  prdata = 32'(num_states_q);
      REG_NUM_SYMBOLS: prdata = 32'(num_symbols_q);
      default:         prdata = '0;
    endcase
  end

  // Saturate sizes to the supported range
  always_comb begin
    if (num_states_q == '0) begin
      ns = CW'(1);
    end else if (8'(num_states_q) > 8'(MAX_STATES)) begin
      ns = CW'(MAX_STATES);
    end else begin
      ns = CW'(num_states_q);
    end
    if (num_symbols_q == '0) begin
      nsym = YCW'(1);
    end else if (8'(num_symbols_q) > 8'(MAX_SYMBOLS)) begin
      nsym = YCW'(MAX_SYMBOLS);
    end else begin
      nsym = YCW'(num_symbols_q);
    end
  end

  enr_front #(
    .CW  (CW),
    .YCW (YCW)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .src_state_i  (src_state_i),
    .symbol_i     (symbol_i),
    .dst_state_i  (dst_state_i),
    .is_epsilon_i (is_epsilon_i),
    .ns_i         (ns),
    .nsym_i       (nsym),
    .q_full_i     (q_full),
    .busy_clear_i (busy_clear),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  enr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  enr_back #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .CW          (CW),
    .YCW         (YCW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ns_i           (ns),
    .nsym_i         (nsym),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .busy_clear_o   (busy_clear),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .from_state_o   (from_state_o),
    .out_symbol_o   (out_symbol_o),
    .target_mask_o  (target_mask_o),
    .closure_mask_o (closure_mask_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
